[rtl/ncs_pkg.sv]
// Package for the nearest codeword search unit.
// Holds sizes, register indexes, word structs and the sequencer state type.
// No dependencies.
`default_nettype none

package ncs_pkg;

   // Store sizes
   localparam int MAX_DIM     = 16;
   localparam int MAX_CODES   = 64;
   localparam int SAMPLE_BITS = 16;

   localparam int DIM_W    = $clog2(MAX_DIM);
   localparam int CODE_W   = $clog2(MAX_CODES);
   localparam int ADDR_W   = CODE_W + DIM_W;
   localparam int DIFF_W   = SAMPLE_BITS + 1;
   localparam int DIST_W   = 31;
   localparam int VLEN_W   = 5;
   localparam int CODES_W  = 7;

   // Distance saturation and the largest difference whose square stays below it
   localparam logic [DIST_W-1:0] DIST_CAP = 31'h7FFF_FFFF;
   localparam logic signed [DIFF_W-1:0] SQ_LIMIT = 17'sd46340;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] REG_VECTOR_LENGTH    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CODEBOOK_ENTRIES = 1'b1;

   // Item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic                          mode;
      logic [CODE_W-1:0]             code_index;
      logic [DIM_W-1:0]              element_index;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic                          last;
   } req_word_type;

   typedef struct packed {
      logic [CODE_W-1:0] label;
      logic [DIST_W-1:0] best_distance;
   } rsp_word_type;

   // Tag that travels with each element through the distance pipeline
   typedef struct packed {
      logic              valid;
      logic              first_elem;
      logic              last_elem;
      logic              last_code;
      logic [CODE_W-1:0] code;
   } stage_tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN,
      ST_WAIT
   } seq_state_type;

endpackage

`default_nettype wire

[rtl/nearest_codeword_search_unit.sv]
// Nearest codeword search unit: codebook and query stores, full-search distance pipeline.
// Depends on ncs_pkg.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   request | req_valid, req_ready, req_payload          | in
//   result  | rsp_valid, rsp_ready, rsp_payload          | out
//   config  | csr_write_enable, csr_index, csr_data      | in
//
// Load words and query words without last are each taken while the unit is idle.
// A query word with last starts a search over codebook_entries x vector_length
// elements, one codebook memory read per cycle, and then the pipeline drains
// before the next word is taken.
// The result sits in an output register; a search may run while it waits to be taken,
// but a finished search holds the input until that register is free.
// Reset is synchronous; the stores hold nothing meaningful until written.
`default_nettype none

module nearest_codeword_search_unit (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  ncs_pkg::req_word_type                   req_payload,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output ncs_pkg::rsp_word_type                   rsp_payload,
   input  wire                                     csr_write_enable,
   input  wire  [ncs_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire  [ncs_pkg::CSR_DATA_W-1:0]          csr_data
);

   // Stores
   logic signed [ncs_pkg::SAMPLE_BITS-1:0] cb_mem [0:ncs_pkg::MAX_CODES*ncs_pkg::MAX_DIM-1];
   logic signed [ncs_pkg::SAMPLE_BITS-1:0] q_mem  [0:ncs_pkg::MAX_DIM-1];

   // Configuration, kept as last index in range
   logic [ncs_pkg::DIM_W-1:0]  dim_last_ff,  dim_last_in;
   logic [ncs_pkg::CODE_W-1:0] code_last_ff, code_last_in;

   // Sequencer
   ncs_pkg::seq_state_type state_ff, state_in;
   logic [ncs_pkg::CODE_W-1:0] code_cnt_ff, code_cnt_in;
   logic [ncs_pkg::DIM_W-1:0]  elem_cnt_ff, elem_cnt_in;
   logic accept, start, issue, load_rsp;
   logic slot_free;
   ncs_pkg::stage_tag_type issue_tag;

   // Pipeline
   ncs_pkg::stage_tag_type s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff;
   logic signed [ncs_pkg::SAMPLE_BITS-1:0] cb_rd_ff, q_rd_ff;
   logic signed [ncs_pkg::DIFF_W-1:0]      diff_ff, diff_in;
   logic                                   big_ff, big_in, sq_big_ff;
   logic signed [2*ncs_pkg::DIFF_W-1:0]    prod;
   logic [ncs_pkg::DIST_W-1:0]             sq_ff, sq_in;
   logic [ncs_pkg::DIST_W-1:0]             acc_ff, acc_in, acc_base;
   logic [ncs_pkg::DIST_W:0]               sum;
   logic                                   done_ff;

   // Best so far
   logic [ncs_pkg::CODE_W-1:0] best_index_ff;
   logic [ncs_pkg::DIST_W-1:0] best_score_ff;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   ncs_pkg::rsp_word_type rsp_payload_ff;

   assign accept = req_valid && req_ready;
   assign start  = accept && req_payload.mode == ncs_pkg::MODE_QUERY && req_payload.last;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Saturate register writes into range
   always_comb begin
      dim_last_in  = dim_last_ff;
      code_last_in = code_last_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ncs_pkg::REG_VECTOR_LENGTH: begin
               if (csr_data[ncs_pkg::VLEN_W-1:0] == '0)
                  dim_last_in = '0;
               else if (csr_data[ncs_pkg::VLEN_W-1:0] > ncs_pkg::VLEN_W'(ncs_pkg::MAX_DIM))
                  dim_last_in = ncs_pkg::DIM_W'(ncs_pkg::MAX_DIM - 1);
               else
                  dim_last_in = ncs_pkg::DIM_W'(csr_data[ncs_pkg::VLEN_W-1:0] - 1'b1);
            end
            ncs_pkg::REG_CODEBOOK_ENTRIES: begin
               if (csr_data[ncs_pkg::CODES_W-1:0] == '0)
                  code_last_in = '0;
               else if (csr_data[ncs_pkg::CODES_W-1:0] > ncs_pkg::CODES_W'(ncs_pkg::MAX_CODES))
                  code_last_in = ncs_pkg::CODE_W'(ncs_pkg::MAX_CODES - 1);
               else
                  code_last_in = ncs_pkg::CODE_W'(csr_data[ncs_pkg::CODES_W-1:0] - 1'b1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_last_ff  <= ncs_pkg::DIM_W'(7);
         code_last_ff <= ncs_pkg::CODE_W'(15);
      end else begin
         dim_last_ff  <= dim_last_in;
         code_last_ff <= code_last_in;
      end
   end

   // Write the stores on accepted words
   always_ff @(posedge clock) begin
      if (accept && req_payload.mode == ncs_pkg::MODE_LOAD)
         cb_mem[{req_payload.code_index, req_payload.element_index}] <= req_payload.sample_value;
   end

   always_ff @(posedge clock) begin
      if (accept && req_payload.mode == ncs_pkg::MODE_QUERY)
         q_mem[req_payload.element_index] <= req_payload.sample_value;
   end

   // Read both stores at the sweep position
   always_ff @(posedge clock) begin
      cb_rd_ff <= cb_mem[{code_cnt_ff, elem_cnt_ff}];
      q_rd_ff  <= q_mem[elem_cnt_ff];
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ncs_pkg::ST_IDLE: begin
            if (start)
               state_in = ncs_pkg::ST_SEARCH;
         end
         ncs_pkg::ST_SEARCH: begin
            if (issue_tag.last_code)
               state_in = ncs_pkg::ST_DRAIN;
         end
         ncs_pkg::ST_DRAIN: begin
            if (done_ff)
               state_in = slot_free ? ncs_pkg::ST_IDLE : ncs_pkg::ST_WAIT;
         end
         ncs_pkg::ST_WAIT: begin
            if (slot_free)
               state_in = ncs_pkg::ST_IDLE;
         end
         default: state_in = ncs_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ncs_pkg::ST_IDLE:   req_ready = 1'b1;
         ncs_pkg::ST_SEARCH: issue     = 1'b1;
         ncs_pkg::ST_DRAIN:  load_rsp  = done_ff && slot_free;
         ncs_pkg::ST_WAIT:   load_rsp  = slot_free;
         default: begin
         end
      endcase
   end

   // Tag for the element read this cycle
   always_comb begin
      issue_tag.valid      = issue;
      issue_tag.first_elem = elem_cnt_ff == '0;
      issue_tag.last_elem  = elem_cnt_ff == dim_last_ff;
      issue_tag.last_code  = issue && elem_cnt_ff == dim_last_ff && code_cnt_ff == code_last_ff;
      issue_tag.code       = code_cnt_ff;
   end

   // Advance the sweep position
   always_comb begin
      code_cnt_in = code_cnt_ff;
      elem_cnt_in = elem_cnt_ff;
      if (start) begin
         code_cnt_in = '0;
         elem_cnt_in = '0;
      end else if (issue) begin
         if (issue_tag.last_elem) begin
            elem_cnt_in = '0;
            code_cnt_in = code_cnt_ff + 1'b1;
         end else begin
            elem_cnt_in = elem_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ncs_pkg::ST_IDLE;
         code_cnt_ff <= '0;
         elem_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         code_cnt_ff <= code_cnt_in;
         elem_cnt_ff <= elem_cnt_in;
      end
   end

   // Difference and range check
   always_comb begin
      diff_in = ncs_pkg::DIFF_W'(q_rd_ff) - ncs_pkg::DIFF_W'(cb_rd_ff);
      big_in  = diff_in > ncs_pkg::SQ_LIMIT || diff_in < -ncs_pkg::SQ_LIMIT;
   end

   // Square; an out-of-range difference is flagged instead
   always_comb begin
      prod  = diff_ff * diff_ff;
      sq_in = big_ff ? '0 : prod[ncs_pkg::DIST_W-1:0];
   end

   // Accumulate with saturation at the cap
   always_comb begin
      acc_base = s4_tag_ff.valid && !s3_tag_ff.first_elem ? acc_ff : '0;
      sum      = {1'b0, acc_base} + {1'b0, sq_ff};
      if (sq_big_ff || sum >= {1'b0, ncs_pkg::DIST_CAP})
         acc_in = ncs_pkg::DIST_CAP;
      else
         acc_in = sum[ncs_pkg::DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      big_ff    <= big_in;
      sq_ff     <= sq_in;
      sq_big_ff <= big_ff;
      if (s3_tag_ff.valid)
         acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         s4_tag_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         s1_tag_ff <= issue_tag;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s3_tag_ff;
         done_ff   <= s4_tag_ff.valid && s4_tag_ff.last_code;
      end
   end

   // Restart the best at search start, keep strictly smaller distances
   always_ff @(posedge clock) begin
      if (reset || start) begin
         best_index_ff <= '0;
         best_score_ff <= ncs_pkg::DIST_CAP;
      end else if (s4_tag_ff.valid && s4_tag_ff.last_elem && acc_ff < best_score_ff) begin
         best_index_ff <= s4_tag_ff.code;
         best_score_ff <= acc_ff;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_rsp)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_payload_ff.label         <= best_index_ff;
         rsp_payload_ff.best_distance <= best_score_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // No word is taken while elements are still in the pipeline
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(s1_tag_ff.valid || s2_tag_ff.valid || s3_tag_ff.valid
                      || s4_tag_ff.valid))
      else $error("word accepted with search in flight");

   // Completion only arrives while draining
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == ncs_pkg::ST_DRAIN)
      else $error("search completion outside drain");

   // The best distance never grows within a search
   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (state_ff == ncs_pkg::ST_SEARCH || state_ff == ncs_pkg::ST_DRAIN)
      && ($past(state_ff) == ncs_pkg::ST_SEARCH || $past(state_ff) == ncs_pkg::ST_DRAIN)
      |-> best_score_ff <= $past(best_score_ff))
      else $error("best distance increased during search");

   // A result is loaded only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> slot_free)
      else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
